>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the pulse capture block.
// Each macro expands to one labeled concurrent assertion reporting by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RPCS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RPCS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/rpcs_pkg.sv
// Package of the RC pulse capture block: sizes, constants, codes and types.
// No dependencies; rpcs_if, rpcs_div and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package rpcs_pkg;

	// Structure
	localparam int CHANNELS     = 8;
	localparam int COUNTER_BITS = 16;
	localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int WID_W        = COUNTER_BITS + 1;

	// Field widths
	localparam int CH_FIELD_W = 3;
	localparam int CNT_W      = 16;
	localparam int TPU_W      = 8;
	localparam int USED_W     = 4;
	localparam int VAL_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Memory entry: rise time above, last width below
	localparam int ENTRY_W = CNT_W + WID_W;

	// Scaling constants
	localparam int OFFSET_US = 880;
	// 8*d/5 reaches 2048 at this d, so this d and larger saturate
	localparam int SAT_D     = 1280;
	localparam int SAT_D_W   = 11;
	localparam int X8_W      = SAT_D_W + 3;
	localparam int RECIP_SH  = 18;
	localparam logic [15:0] RECIP_5 = 16'd52429;
	localparam int PROD_W    = X8_W + 16;
	localparam logic [VAL_W-1:0] VALUE_MAX    = 11'd2047;
	localparam logic [VAL_W-1:0] UNUSED_VALUE = 11'd1025;

	// Reset values of the registers
	localparam logic [TPU_W-1:0]  TPU_RST  = 8'd1;
	localparam logic [CNT_W-1:0]  TMAX_RST = 16'hFFFF;
	localparam logic [USED_W-1:0] USED_RST = 4'd8;

	// Request codes
	localparam logic REQ_EDGE = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TPU  = 2'd0,
		CFG_TMAX = 2'd1,
		CFG_USED = 2'd2
	} cfg_idx_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_SCALE,
		ST_EMIT
	} state_t;

	// Divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

>>> hdl/rpcs_if.sv
// Valid/ready channel interfaces of the pulse capture block.
// Depends on rpcs_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rpcs_in_if;
	import rpcs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  req_type;
	logic [CH_FIELD_W-1:0] channel;
	logic [CNT_W-1:0]      capture_time;

	modport source(output valid, req_type, channel, capture_time, input ready);
	modport sink(input valid, req_type, channel, capture_time, output ready);
endinterface

interface rpcs_out_if;
	import rpcs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CH_FIELD_W-1:0] out_channel;
	logic [VAL_W-1:0]      value;
	logic                  fresh;

	modport source(output valid, out_channel, value, fresh, input ready);
	modport sink(input valid, out_channel, value, fresh, output ready);
endinterface

`default_nettype wire

>>> hdl/rpcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rpcs_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 33
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/rpcs_div.sv
// Restoring divider, one quotient bit per cycle: pulse width by ticks per microsecond.
// Depends on rpcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpcs_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [rpcs_pkg::WID_W-1:0] dividend,
	input  wire logic [rpcs_pkg::TPU_W-1:0] divisor,
	output rpcs_pkg::div_stat_t           stat,
	output logic      [rpcs_pkg::WID_W-1:0] quotient
);
	import rpcs_pkg::*;

	localparam int CNT_BITS = $clog2(WID_W + 1);

	logic [CNT_BITS-1:0] cnt_q;
	logic                done_q;
	logic [WID_W-1:0]    dq_q;
	logic [TPU_W-1:0]    rem_q;
	logic [TPU_W-1:0]    div_q;
	logic [TPU_W:0]      rem_sh;
	logic [TPU_W:0]      diff;
	logic                ge;

	// One trial subtraction
	always_comb begin
		rem_sh = {rem_q, dq_q[WID_W-1]};
		diff   = rem_sh - {1'b0, div_q};
		ge     = rem_sh >= {1'b0, div_q};
	end

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_BITS'(WID_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: zero divisor is taken as one
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= (divisor == '0) ? TPU_W'(1) : divisor;
		end else if (cnt_q != '0) begin
			dq_q  <= {dq_q[WID_W-2:0], ge};
			rem_q <= ge ? diff[TPU_W-1:0] : rem_sh[TPU_W-1:0];
		end
	end

	assign stat.busy = cnt_q != '0;
	assign stat.done = done_q;
	assign quotient  = dq_q;

endmodule

`default_nettype wire

>>> hdl/rc_pwm_capture_to_sbus_value_top.sv
// Top level of the RC pulse capture block: sequencer, channel memory, scaling.
// Depends on rpcs_pkg, rpcs_if, rpcs_ram, rpcs_div and assert_macros.svh.
//
// Usage:
// - in_ch carries capture events (req_type 0: channel, counter value) and
//   read requests (req_type 1: channel). Events alternate per channel between
//   rising and falling edge; a falling edge stores the pulse width in ticks.
// - out_ch returns one transaction per read: channel, scaled value 0..2047
//   ((width/ticks_per_us - 880) * 8/5, clamped), and fresh. An unseen channel
//   reads 0, a channel at or above used_channels reads 1025.
// - Configuration is written through cfg_we/cfg_idx/cfg_wdata while idle.
// - One item is processed at a time. A capture event is applied in ST_READ.
//   A read of an unseen or unused channel passes ST_READ and ST_EMIT into the
//   output register; a read of a seen channel passes ST_READ, ST_DIV, ST_SCALE
//   and ST_EMIT, the bit-serial divider delivering one quotient bit per cycle.
//   The next transaction is accepted in the cycle after the result loads.
// - Channel state sits in a small RAM whose data arrives in the cycle after
//   acceptance; phase, seen and entry-valid flags are flip-flops cleared by
//   reset, so the block is ready right after reset with no clearing pass.
// - A stalled receiver holds the result in the output register; the next
//   item is still accepted and waits only when its own result is ready.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rc_pwm_capture_to_sbus_value_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	rpcs_in_if.sink                              in_ch,
	rpcs_out_if.source                           out_ch,
	input  wire logic                            cfg_we,
	input  wire logic [rpcs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [rpcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import rpcs_pkg::*;

	// Configuration
	logic [TPU_W-1:0]  tpu_q;
	logic [CNT_W-1:0]  tmax_q;
	logic [USED_W-1:0] used_q;

	// Sequencer and latched request
	state_t                state_q, state_d;
	logic                  req_q;
	logic [CH_FIELD_W-1:0] ch_q;
	logic [CNT_W-1:0]      t_q;
	logic [CH_W-1:0]       idx;
	logic                  in_range;
	logic                  unused_ch;

	// Per-channel flags
	logic [CHANNELS-1:0] phase_q;
	logic [CHANNELS-1:0] seen_q;
	logic [CHANNELS-1:0] wvalid_q;

	// Memory access
	logic               mem_we;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [ENTRY_W-1:0] mem_rdata;
	logic [ENTRY_W-1:0] entry;
	logic [CNT_W-1:0]   rise;
	logic [WID_W-1:0]   width_old;
	logic [WID_W-1:0]   width_new;

	// Divider and scaling
	logic             div_start;
	div_stat_t        div_stat;
	logic [WID_W-1:0] quot;
	logic             short_p;
	logic             long_p;
	logic [SAT_D_W-1:0] d_low;
	logic [X8_W-1:0]    x8;
	logic [PROD_W-1:0]  prod;
	logic [VAL_W-1:0]   scaled;

	// Result and output registers
	logic [VAL_W-1:0]      res_val_q;
	logic                  res_fresh_q;
	logic                  out_load;
	logic                  out_valid_q;
	logic [CH_FIELD_W-1:0] out_ch_q;
	logic [VAL_W-1:0]      out_val_q;
	logic                  out_fresh_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q  <= TPU_RST;
			tmax_q <= TMAX_RST;
			used_q <= USED_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_TPU:  tpu_q  <= cfg_wdata[TPU_W-1:0];
				CFG_TMAX: tmax_q <= cfg_wdata[CNT_W-1:0];
				CFG_USED: used_q <= cfg_wdata[USED_W-1:0];
				default:  ;
			endcase
		end
	end

	// Latch the accepted request
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			req_q <= in_ch.req_type;
			ch_q  <= in_ch.channel;
			t_q   <= in_ch.capture_time;
		end
	end

	assign idx       = CH_W'(ch_q);
	assign in_range  = int'(ch_q) < CHANNELS;
	assign unused_ch = (USED_W'(ch_q) >= used_q) || !in_range;

	// Channel memory: rise time and last width
	rpcs_ram #(
		.DEPTH(CHANNELS),
		.WIDTH(ENTRY_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(idx),
		.wdata(mem_wdata),
		.raddr(CH_W'(in_ch.channel)),
		.rdata(mem_rdata)
	);

	// Entry decode; a never written entry reads as zero
	always_comb begin
		entry     = wvalid_q[idx] ? mem_rdata : '0;
		rise      = entry[WID_W +: CNT_W];
		width_old = entry[WID_W-1:0];
		if (rise < t_q) begin
			width_new = WID_W'(t_q) - WID_W'(rise);
		end else begin
			width_new = {1'b0, tmax_q} - {1'b0, rise} + {1'b0, t_q} + WID_W'(1);
		end
	end

	// Bit-serial divider
	rpcs_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(width_old),
		.divisor (tpu_q),
		.stat    (div_stat),
		.quotient(quot)
	);

	// Offset, saturate, and multiply by 8/5 through a reciprocal
	always_comb begin
		short_p = int'(quot) < OFFSET_US;
		long_p  = int'(quot) >= (OFFSET_US + SAT_D);
		d_low   = SAT_D_W'(quot - WID_W'(OFFSET_US));
		x8      = {d_low, 3'b000};
		prod    = PROD_W'(x8) * PROD_W'(RECIP_5);
		if (short_p) begin
			scaled = '0;
		end else if (long_p) begin
			scaled = VALUE_MAX;
		end else begin
			scaled = prod[RECIP_SH +: VAL_W];
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control
	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		mem_we      = 1'b0;
		mem_wdata   = {rise, width_new};
		div_start   = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (req_q == REQ_EDGE) begin
					mem_we = in_range;
					if (!phase_q[idx]) begin
						mem_wdata = {t_q, width_old};
					end
					state_d = ST_IDLE;
				end else if (!unused_ch && seen_q[idx]) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Per-channel flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			seen_q   <= '0;
			wvalid_q <= '0;
		end else if (state_q == ST_READ && in_range) begin
			if (req_q == REQ_EDGE) begin
				wvalid_q[idx] <= 1'b1;
				phase_q[idx]  <= !phase_q[idx];
				if (!phase_q[idx]) begin
					seen_q[idx] <= 1'b1;
				end
			end else if (!unused_ch) begin
				seen_q[idx] <= 1'b0;
			end
		end
	end

	// Result staging
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			if (unused_ch) begin
				res_val_q   <= UNUSED_VALUE;
				res_fresh_q <= 1'b0;
			end else begin
				res_val_q   <= '0;
				res_fresh_q <= seen_q[idx];
			end
		end else if (state_q == ST_SCALE) begin
			res_val_q <= scaled;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch_q    <= ch_q;
			out_val_q   <= res_val_q;
			out_fresh_q <= res_fresh_q;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_channel = out_ch_q;
	assign out_ch.value       = out_val_q;
	assign out_ch.fresh       = out_fresh_q;

	// Checks
	`RPCS_ASSERT_NXT(a_accept_reads, clk, arst_n, in_ch.valid && in_ch.ready,
		state_q == ST_READ, "accepted transaction did not enter the memory read")
	`RPCS_ASSERT_IMP(a_we_edge_only, clk, arst_n, mem_we,
		state_q == ST_READ && req_q == REQ_EDGE, "memory written outside an edge update")
	`RPCS_ASSERT_IMP(a_div_running, clk, arst_n, state_q == ST_DIV && !div_stat.done,
		div_stat.busy, "waiting on divider that is not running")
	`RPCS_ASSERT_IMP(a_fresh_used, clk, arst_n, out_valid_q && out_fresh_q,
		USED_W'(out_ch_q) < used_q, "fresh result on an unused channel")

endmodule

`default_nettype wire
